// ===== src/slcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// slcfp_pkg
// shared types and constants for the serial led command frame parser
// ----------------------------------------------------------------------------
package slcfp_pkg;

   localparam int FRAME_LENGTH = 7;

   localparam logic [7:0] FIRST_HEADER  = 8'h55;
   localparam logic [7:0] SECOND_HEADER = 8'hAA;

   localparam logic [7:0] COMMAND_CODE_RESET = 8'h06;
   localparam logic [7:0] MAX_LENGTH_RESET   = 8'h07;

   // register indexes on the csr port
   localparam logic CSR_COMMAND_CODE = 1'b0;
   localparam logic CSR_MAX_LENGTH   = 1'b1;

   // command queue between parser and output stage
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] led_index;
      logic       led_turn_on;
   } led_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== src/slcfp_front.sv =====
// ----------------------------------------------------------------------------
// slcfp_front
// byte parser: hunts headers, checks length and xor, emits led commands
// ----------------------------------------------------------------------------
module slcfp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_accept,
   input  logic [7:0]               rx_byte,
   input  logic                     csr_write_enable,
   input  logic                     csr_index,
   input  logic [7:0]               csr_write_data,
   output logic                     cmd_push,
   output slcfp_pkg::led_cmd_type   cmd_data
);
   import slcfp_pkg::*;

   typedef enum logic [2:0] {
      POS_HUNT     = 3'd0,
      POS_HEADER2  = 3'd1,
      POS_LENGTH   = 3'd2,
      POS_FUNCTION = 3'd3,
      POS_INDEX    = 3'd4,
      POS_SWITCH   = 3'd5,
      POS_CHECK    = 3'(FRAME_LENGTH - 1)
   } pos_type;

   pos_type    pos_ff,    pos_in;
   logic [7:0] check_ff,  check_in;
   logic [7:0] func_ff,   func_in;
   logic [7:0] index_ff,  index_in;
   logic [7:0] switch_ff, switch_in;
   logic [7:0] cmd_code_ff;
   logic [7:0] max_len_ff;
   logic       good_frame;

   assign good_frame = (rx_byte == check_ff) && (func_ff == cmd_code_ff);
   assign cmd_push   = byte_accept && (pos_ff == POS_CHECK) && good_frame;
   assign cmd_data   = '{led_index: index_ff, led_turn_on: (switch_ff != 8'h00)};

   always_comb begin
      pos_in    = pos_ff;
      check_in  = check_ff;
      func_in   = func_ff;
      index_in  = index_ff;
      switch_in = switch_ff;
      if (byte_accept) begin
         unique case (pos_ff)
            POS_HUNT: begin
               if (rx_byte == FIRST_HEADER) begin
                  check_in = rx_byte;
                  pos_in   = POS_HEADER2;
               end
            end
            POS_HEADER2: begin
               // bad second header is dropped, not re-examined
               if (rx_byte == SECOND_HEADER) begin
                  check_in = check_ff ^ rx_byte;
                  pos_in   = POS_LENGTH;
               end else begin
                  check_in = 8'h00;
                  pos_in   = POS_HUNT;
               end
            end
            POS_LENGTH: begin
               if (rx_byte <= max_len_ff) begin
                  check_in = check_ff ^ rx_byte;
                  pos_in   = POS_FUNCTION;
               end else begin
                  check_in = 8'h00;
                  pos_in   = POS_HUNT;
               end
            end
            POS_FUNCTION: begin
               func_in  = rx_byte;
               check_in = check_ff ^ rx_byte;
               pos_in   = POS_INDEX;
            end
            POS_INDEX: begin
               index_in = rx_byte;
               check_in = check_ff ^ rx_byte;
               pos_in   = POS_SWITCH;
            end
            POS_SWITCH: begin
               switch_in = rx_byte;
               check_in  = check_ff ^ rx_byte;
               pos_in    = POS_CHECK;
            end
            POS_CHECK: begin
               check_in = 8'h00;
               pos_in   = POS_HUNT;
            end
            default: begin
               check_in = 8'h00;
               pos_in   = POS_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= POS_HUNT;
         check_ff    <= 8'h00;
         func_ff     <= 8'h00;
         index_ff    <= 8'h00;
         switch_ff   <= 8'h00;
         cmd_code_ff <= COMMAND_CODE_RESET;
         max_len_ff  <= MAX_LENGTH_RESET;
      end else begin
         pos_ff    <= pos_in;
         check_ff  <= check_in;
         func_ff   <= func_in;
         index_ff  <= index_in;
         switch_ff <= switch_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_COMMAND_CODE: cmd_code_ff <= csr_write_data;
               CSR_MAX_LENGTH:   max_len_ff  <= csr_write_data;
               default:          cmd_code_ff <= cmd_code_ff;
            endcase
         end
      end
   end

endmodule

// ===== src/slcfp_queue.sv =====
// ----------------------------------------------------------------------------
// slcfp_queue
// short fifo of decoded led commands between parser and output stage
// ----------------------------------------------------------------------------
module slcfp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  slcfp_pkg::led_cmd_type        push_data,
   input  logic                          pop,
   output slcfp_pkg::led_cmd_type        pop_data,
   output slcfp_pkg::queue_status_type   status
);
   import slcfp_pkg::*;

   led_cmd_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff,  count_in;

   assign status.full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/slcfp_back.sv =====
// ----------------------------------------------------------------------------
// slcfp_back
// output stage: pulls commands from the queue into the response register
// ----------------------------------------------------------------------------
module slcfp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  slcfp_pkg::queue_status_type   status,
   input  slcfp_pkg::led_cmd_type        pop_data,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_led_index,
   output logic                          rsp_led_turn_on
);
   import slcfp_pkg::*;

   logic        valid_ff;
   led_cmd_type data_ff;

   // refill whenever the register is empty or being drained
   assign pop             = !status.empty && (!valid_ff || rsp_ready);
   assign rsp_valid       = valid_ff;
   assign rsp_led_index   = data_ff.led_index;
   assign rsp_led_turn_on = data_ff.led_turn_on;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= pop_data;
      end
   end

endmodule

// ===== src/serial_led_command_frame_parser.sv =====
// ----------------------------------------------------------------------------
// serial_led_command_frame_parser
// Takes one received serial byte per transfer on req_ and searches the stream
// for seven-byte frames: 0x55, 0xAA, length, function, led index, on/off and
// an xor check byte over the first six. A length above max_length or a bad
// header byte drops that byte and restarts the hunt; a bad check drops the
// whole frame. A good frame whose function byte equals command_code gives one
// rsp_ transfer with the led index and on/off (nonzero on/off byte means on);
// all other frames give nothing. The block takes one byte every cycle while
// req_ready is high; a command passes through the command queue and the
// response register before rsp_valid rises. Byte intake only stalls while
// the two-entry command queue is full, which needs the response register
// to be held long enough for two more commands to queue up behind it.
// Registers on csr_: index 0 command_code (reset 0x06), index 1 max_length
// (reset 0x07); write them only while the block is idle.
// ----------------------------------------------------------------------------
module serial_led_command_frame_parser (
   input  logic       clock,
   input  logic       reset,
   // byte input channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   // led command output channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_led_index,
   output logic       rsp_led_turn_on,
   // register write port
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data
);
   import slcfp_pkg::*;

   logic             byte_accept;
   logic             cmd_push;
   led_cmd_type      cmd_data;
   logic             cmd_pop;
   led_cmd_type      pop_data;
   queue_status_type q_status;

   // hold off bytes only while a command could not be stored
   assign req_ready   = !q_status.full;
   assign byte_accept = req_valid && req_ready;

   // front: frame parser and registers
   slcfp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .byte_accept      (byte_accept),
      .rx_byte          (req_rx_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd_push         (cmd_push),
      .cmd_data         (cmd_data)
   );

   // decouples parser from response backpressure
   slcfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .pop       (cmd_pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   // back: registered response stage
   slcfp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .status          (q_status),
      .pop_data        (pop_data),
      .pop             (cmd_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_led_index   (rsp_led_index),
      .rsp_led_turn_on (rsp_led_turn_on)
   );

endmodule

// ===== src/slcfp_checker.sv =====
// ----------------------------------------------------------------------------
// slcfp_checker
// port-level checks for the serial led command frame parser
// ----------------------------------------------------------------------------
module slcfp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_led_index,
   input logic       rsp_led_turn_on
);

   // after reset nothing is pending and bytes are taken
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("slcfp: not clean after reset");

   // byte intake only stalls while a response is held
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("slcfp: req stalled with no response pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("slcfp: response dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_led_index) && $stable(rsp_led_turn_on)))
      else $error("slcfp: response payload changed while stalled");

endmodule

bind serial_led_command_frame_parser slcfp_checker u_slcfp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_led_index   (rsp_led_index),
   .rsp_led_turn_on (rsp_led_turn_on)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial led command frame parser. Byte streams
// go in on req_ and led commands come back on rsp_. A built-in frame tracker
// decodes every byte that is taken and queues the led command it should
// produce; each rsp_ transfer is checked against the oldest queued command.
// Directed frames cover header, length, check and function errors; random
// traffic then runs under several register settings, the extremes included.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import slcfp_pkg::*;

   localparam int LIMIT_CYCLES   = 400000;
   localparam int SETTLE_CYCLES  = 10;
   localparam int RANDOM_BYTES   = 800;

   // position inside the frame, counted in bytes already taken
   typedef enum logic [2:0] {
      HUNT_FIRST,
      GOT_FIRST,
      GOT_SECOND,
      GOT_LENGTH,
      GOT_FUNCTION,
      GOT_INDEX,
      AT_CHECK
   } frame_pos_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_led_index;
   logic       rsp_led_turn_on;
   logic       csr_write_enable = 1'b0;
   logic       csr_index = CSR_COMMAND_CODE;
   logic [7:0] csr_write_data = 8'h00;

   // frame tracker state and its copy of the registers
   frame_pos_type trk_pos = HUNT_FIRST;
   logic [7:0]    trk_xor = 8'h00;
   logic [7:0]    trk_function = 8'h00;
   logic [7:0]    trk_index = 8'h00;
   logic [7:0]    trk_switch = 8'h00;
   logic [7:0]    cfg_command_code = COMMAND_CODE_RESET;
   logic [7:0]    cfg_max_length = MAX_LENGTH_RESET;

   led_cmd_type   pending_cmds[$];
   led_cmd_type   expected_cmd;

   int            error_count = 0;
   int            cycle_count = 0;
   int            bytes_sent = 0;

   // sender pacing
   int            burst_left = 1;
   bit            sender_active = 1'b0;

   // receiver stall pattern
   int            recv_mode = 0;
   int            recv_mode_left = 0;
   int            recv_stall_left = 0;

   serial_led_command_frame_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_led_index    (rsp_led_index),
      .rsp_led_turn_on  (rsp_led_turn_on),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // run limit, counted from time zero so the reset period is included
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // advance the frame tracker by one taken byte; queue a command when a
   // good frame carries the configured function code
   function automatic void track_byte(input logic [7:0] rx);
      led_cmd_type cmd;
      case (trk_pos)
         HUNT_FIRST: begin
            // noise while hunting is dropped
            if (rx == FIRST_HEADER) begin
               trk_xor = rx;
               trk_pos = GOT_FIRST;
            end
         end
         GOT_FIRST: begin
            // a wrong second header byte is not looked at again
            if (rx == SECOND_HEADER) begin
               trk_xor ^= rx;
               trk_pos = GOT_SECOND;
            end else begin
               trk_xor = 8'h00;
               trk_pos = HUNT_FIRST;
            end
         end
         GOT_SECOND: begin
            if (rx <= cfg_max_length) begin
               trk_xor ^= rx;
               trk_pos = GOT_LENGTH;
            end else begin
               trk_xor = 8'h00;
               trk_pos = HUNT_FIRST;
            end
         end
         GOT_LENGTH: begin
            trk_function = rx;
            trk_xor ^= rx;
            trk_pos = GOT_FUNCTION;
         end
         GOT_FUNCTION: begin
            trk_index = rx;
            trk_xor ^= rx;
            trk_pos = GOT_INDEX;
         end
         GOT_INDEX: begin
            trk_switch = rx;
            trk_xor ^= rx;
            trk_pos = AT_CHECK;
         end
         AT_CHECK: begin
            if (rx == trk_xor && trk_function == cfg_command_code) begin
               cmd.led_index = trk_index;
               cmd.led_turn_on = (trk_switch != 8'h00);
               pending_cmds.push_back(cmd);
            end
            trk_xor = 8'h00;
            trk_pos = HUNT_FIRST;
         end
         default: begin
            trk_xor = 8'h00;
            trk_pos = HUNT_FIRST;
         end
      endcase
   endfunction

   // drop req_valid once, only if it is currently held high
   task automatic release_req();
      if (sender_active) begin
         req_valid <= 1'b0;
         sender_active = 1'b0;
      end
   endtask

   // one byte transfer; the sender runs in random bursts with random gaps
   task automatic send_byte(input logic [7:0] rx);
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      sender_active = 1'b1;
      do @(posedge clock); while (!req_ready);
      track_byte(rx);
      bytes_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         // now and then a long burst with no gaps at all
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            release_req();
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   // send the first byte_count bytes of a frame; check_flip corrupts the check
   task automatic send_frame(input logic [7:0] length, input logic [7:0] func,
                             input logic [7:0] index, input logic [7:0] onoff,
                             input logic [7:0] check_flip, input int byte_count);
      logic [7:0] frame [FRAME_LENGTH];
      frame[0] = FIRST_HEADER;
      frame[1] = SECOND_HEADER;
      frame[2] = length;
      frame[3] = func;
      frame[4] = index;
      frame[5] = onoff;
      frame[6] = FIRST_HEADER ^ SECOND_HEADER ^ length ^ func ^ index ^ onoff ^ check_flip;
      for (int i = 0; i < byte_count; i++) begin
         send_byte(frame[i]);
      end
   endtask

   // hold the sender until every queued command has come back, then let the
   // pipeline settle so a frame with no command is also finished
   task automatic wait_for_idle();
      release_req();
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write both registers back to back while the block is idle
   task automatic set_config(input logic [7:0] command_code,
                             input logic [7:0] max_length);
      wait_for_idle();
      csr_write_enable <= 1'b1;
      csr_index <= CSR_COMMAND_CODE;
      csr_write_data <= command_code;
      @(posedge clock);
      cfg_command_code = command_code;
      csr_index <= CSR_MAX_LENGTH;
      csr_write_data <= max_length;
      @(posedge clock);
      cfg_max_length = max_length;
      csr_write_enable <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // directed tests, run with the reset register values but for the extremes test
   // ------------------------------------------------------------------

   // good frame at the largest allowed length, top led, on/off with only msb set
   task automatic test_good_frame();
      send_frame(MAX_LENGTH_RESET, COMMAND_CODE_RESET, 8'hFF, 8'h80, 8'h00,
                 FRAME_LENGTH);
   endtask

   task automatic test_header_errors();
      // noise while hunting
      send_byte(8'h00);
      send_byte(8'hFF);
      // first header twice: the second one is dropped, so the 0xaa is noise
      send_byte(FIRST_HEADER);
      send_byte(FIRST_HEADER);
      send_byte(SECOND_HEADER);
      // length one above the limit
      send_byte(FIRST_HEADER);
      send_byte(SECOND_HEADER);
      send_byte(MAX_LENGTH_RESET + 8'd1);
   endtask

   task automatic test_check_mismatch();
      send_frame(8'h00, COMMAND_CODE_RESET, 8'h5A, 8'h01, 8'h01, FRAME_LENGTH);
   endtask

   task automatic test_other_function();
      send_frame(8'h03, COMMAND_CODE_RESET + 8'd1, 8'h12, 8'h00, 8'h00,
                 FRAME_LENGTH);
   endtask

   // both registers at their lowest and highest values
   task automatic test_config_extremes();
      set_config(8'h00, 8'h00);
      send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, FRAME_LENGTH);
      send_frame(8'h01, 8'h00, 8'h33, 8'h01, 8'h00, FRAME_LENGTH);
      set_config(8'hFF, 8'hFF);
      send_frame(8'hFF, 8'hFF, 8'hA5, 8'h01, 8'h00, FRAME_LENGTH);
      send_frame(8'hFF, 8'h00, 8'hA5, 8'h01, 8'h00, FRAME_LENGTH);
   endtask

   // ------------------------------------------------------------------
   // random traffic: mostly well-formed frames, plus broken ones and noise
   // ------------------------------------------------------------------

   task automatic send_random_sequence();
      int         kind;
      logic [7:0] length;
      logic [7:0] func;
      logic [7:0] onoff;
      kind = $urandom_range(0, 15);
      length = 8'($urandom_range(0, cfg_max_length));
      func = ($urandom_range(0, 3) != 0) ? cfg_command_code : 8'($urandom());
      onoff = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom());
      if (kind == 12 && cfg_max_length != 8'hFF) begin
         // length too large; whatever follows is treated as noise
         length = 8'($urandom_range(cfg_max_length + 1, 255));
      end
      case (kind)
         10: send_frame(length, func, 8'($urandom()), onoff,
                        8'($urandom_range(1, 255)), FRAME_LENGTH);
         11: send_frame(length, func, 8'($urandom()), onoff, 8'h00,
                        $urandom_range(1, FRAME_LENGTH - 1));
         12: send_frame(length, func, 8'($urandom()), onoff, 8'h00,
                        $urandom_range(3, FRAME_LENGTH));
         13: send_byte(8'($urandom()));
         14: repeat ($urandom_range(1, 5)) send_byte(8'($urandom()));
         15: begin
            send_byte(FIRST_HEADER);
            send_byte(8'($urandom()));
         end
         default: send_frame(length, func, 8'($urandom()), onoff, 8'h00,
                             FRAME_LENGTH);
      endcase
   endtask

   task automatic test_random_traffic();
      int first_byte;
      int phase_bytes;
      first_byte = bytes_sent;
      phase_bytes = RANDOM_BYTES / 5;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_config(8'($urandom()), 8'($urandom()));
            1: set_config(8'h00, 8'h00);
            2: set_config(8'hFF, 8'hFF);
            3: set_config(8'($urandom()), 8'($urandom_range(0, 3)));
            default: set_config(COMMAND_CODE_RESET, MAX_LENGTH_RESET);
         endcase
         while (bytes_sent - first_byte < phase_bytes * (phase + 1)) begin
            send_random_sequence();
         end
      end
   endtask

   // ------------------------------------------------------------------
   // response checking: every rsp_ transfer against the oldest queued command
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cmds.size() == 0) begin
            report_mismatch($sformatf("unexpected command led_index=%0d on=%0b",
                                      rsp_led_index, rsp_led_turn_on));
         end else begin
            expected_cmd = pending_cmds.pop_front();
            if (rsp_led_index !== expected_cmd.led_index) begin
               report_mismatch($sformatf("led_index got %0d want %0d",
                                         rsp_led_index, expected_cmd.led_index));
            end
            if (rsp_led_turn_on !== expected_cmd.led_turn_on) begin
               report_mismatch($sformatf("led_turn_on got %0b want %0b (led %0d)",
                                         rsp_led_turn_on, expected_cmd.led_turn_on,
                                         expected_cmd.led_index));
            end
         end
      end
   end

   // receiver back-pressure: modes of always ready, coin-flip ready and
   // occasional long stalls, with the mode picked anew at random intervals
   always @(posedge clock) begin
      if (recv_mode_left == 0) begin
         recv_mode = $urandom_range(0, 2);
         recv_mode_left = $urandom_range(64, 256);
      end else begin
         recv_mode_left--;
      end
      if (recv_stall_left > 0) begin
         recv_stall_left--;
         rsp_ready <= 1'b0;
      end else if (recv_mode == 1 && $urandom_range(0, 1) == 0) begin
         rsp_ready <= 1'b0;
      end else if (recv_mode == 2 && $urandom_range(0, 15) == 0) begin
         recv_stall_left = $urandom_range(1, 20);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_good_frame();
      test_header_errors();
      test_check_mismatch();
      test_other_function();
      test_config_extremes();
      test_random_traffic();
      // drain everything and let late or extra commands show up
      wait_for_idle();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/slcfp_pkg.sv
src/slcfp_front.sv
src/slcfp_queue.sv
src/slcfp_back.sv
src/serial_led_command_frame_parser.sv
src/slcfp_checker.sv
sim/tb_top.sv
